/* hdl/ptw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, codes and types for the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int VA_W       = 48;
  localparam int PTE_W      = 64;
  localparam int ADDR_W     = 52;
  localparam int ROOT_W     = 40;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = 9;

  localparam int PHYS_ADDR_BITS_DEF = 52;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // Input command codes.
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_REPLY     = 1'b1;

  // Result kind codes.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Page size codes.
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // Table levels, named after the entry that is awaited.
  localparam logic [1:0] LVL_PT   = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PML4 = 2'd3;

  // PTE bit positions.
  localparam int PTE_PRESENT = 0;
  localparam int PTE_LARGE   = 7;

  // One classified beat as it travels through the queue. For a translate the
  // data holds the virtual address; for a reply it holds the frame bits of
  // the entry with the page offset cleared.
  typedef struct packed {
    logic              reply;
    logic              present;
    logic              big_page;
    logic [ADDR_W-1:0] data;
  } item_t;

endpackage

/* hdl/ptw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_front
// Accepts input beats and classifies them into queue items.
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [ptw_pkg::VA_W-1:0]        in_virtual_address,
  input  logic [ptw_pkg::PTE_W-1:0]       in_entry_data,
  input  logic                            q_full,
  output logic                            q_push,
  output ptw_pkg::item_t                  q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item = '0;
    unique case (in_cmd)
      ptw_pkg::CMD_TRANSLATE: begin
        q_item.reply = 1'b0;
        q_item.data  = {{(ptw_pkg::ADDR_W - ptw_pkg::VA_W){1'b0}}, in_virtual_address};
      end
      ptw_pkg::CMD_REPLY: begin
        q_item.reply    = 1'b1;
        q_item.present  = in_entry_data[ptw_pkg::PTE_PRESENT];
        q_item.big_page = in_entry_data[ptw_pkg::PTE_LARGE];
        q_item.data     = {in_entry_data[ptw_pkg::ADDR_W-1:ptw_pkg::PAGE_SHIFT],
                           {ptw_pkg::PAGE_SHIFT{1'b0}}};
      end
      default: q_item = '0;
    endcase
  end

endmodule

/* hdl/ptw_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_fifo
// Small register queue between the front and back parts of the walker.
// ----------------------------------------------------------------------------
module ptw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/ptw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_back
// Walk engine: holds the walk state and turns queue items into results.
// ----------------------------------------------------------------------------
module ptw_back #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ptw_pkg::ROOT_W-1:0]  cfg_wr_data,
  input  logic                        head_valid,
  input  ptw_pkg::item_t              head_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [ptw_pkg::ADDR_W-1:0]  out_address,
  output logic                        out_fault,
  output logic [1:0]                  out_map_size
);

  localparam int AW = ptw_pkg::ADDR_W;
  localparam int VW = ptw_pkg::VA_W;
  localparam logic [AW-1:0] PHYS_MASK = {AW{1'b1}} >> (AW - PHYS_ADDR_BITS);

  logic [ptw_pkg::ROOT_W-1:0] root_r;
  logic                       busy_r, busy_nxt;
  logic [1:0]                 lvl_r, lvl_nxt;
  logic [VW-1:0]              va_r, va_nxt;
  logic                       out_valid_r;
  logic                       kind_r, fault_r;
  logic [AW-1:0]              addr_r;
  logic [1:0]                 size_r;

  logic          has_res;
  logic          res_kind, res_fault;
  logic [AW-1:0] res_addr;
  logic [1:0]    res_size;
  logic [1:0]    lvl_dec;
  logic          take_ok;

  // Address of the entry for a level inside the table whose frame is base.
  function automatic logic [AW-1:0] entry_addr(input logic [AW-1:0] base,
                                               input logic [VW-1:0] va,
                                               input logic [1:0]    lvl);
    logic [ptw_pkg::IDX_W-1:0] idx;
    begin
      unique case (lvl)
        ptw_pkg::LVL_PML4: idx = va[47:39];
        ptw_pkg::LVL_PDPT: idx = va[38:30];
        ptw_pkg::LVL_PD:   idx = va[29:21];
        ptw_pkg::LVL_PT:   idx = va[20:12];
        default:           idx = '0;
      endcase
      return {base[AW-1:ptw_pkg::PAGE_SHIFT], idx, 3'b000};
    end
  endfunction

  assign take_ok = !out_valid_r || out_ready;
  assign pop     = head_valid && take_ok;
  assign lvl_dec = lvl_r - 2'd1;

  always_comb begin
    has_res   = 1'b0;
    res_kind  = ptw_pkg::KIND_READ;
    res_addr  = '0;
    res_fault = 1'b0;
    res_size  = ptw_pkg::SIZE_4K;
    busy_nxt  = busy_r;
    lvl_nxt   = lvl_r;
    va_nxt    = va_r;
    if (!head_item.reply) begin
      // A translate while a walk is running is dropped.
      if (!busy_r) begin
        has_res  = 1'b1;
        busy_nxt = 1'b1;
        lvl_nxt  = ptw_pkg::LVL_PML4;
        va_nxt   = head_item.data[VW-1:0];
        res_addr = entry_addr({root_r, {ptw_pkg::PAGE_SHIFT{1'b0}}},
                              head_item.data[VW-1:0], ptw_pkg::LVL_PML4) & PHYS_MASK;
      end
    end else if (busy_r) begin
      has_res = 1'b1;
      if (!head_item.present) begin
        busy_nxt  = 1'b0;
        lvl_nxt   = ptw_pkg::LVL_PT;
        res_kind  = ptw_pkg::KIND_DONE;
        res_fault = 1'b1;
      end else if (lvl_r == ptw_pkg::LVL_PDPT && head_item.big_page) begin
        busy_nxt = 1'b0;
        lvl_nxt  = ptw_pkg::LVL_PT;
        res_kind = ptw_pkg::KIND_DONE;
        res_size = ptw_pkg::SIZE_1G;
        res_addr = ({head_item.data[AW-1:30], 30'b0} & PHYS_MASK)
                 | {{(AW-30){1'b0}}, va_r[29:0]};
      end else if (lvl_r == ptw_pkg::LVL_PD && head_item.big_page) begin
        busy_nxt = 1'b0;
        lvl_nxt  = ptw_pkg::LVL_PT;
        res_kind = ptw_pkg::KIND_DONE;
        res_size = ptw_pkg::SIZE_2M;
        res_addr = ({head_item.data[AW-1:21], 21'b0} & PHYS_MASK)
                 | {{(AW-21){1'b0}}, va_r[20:0]};
      end else if (lvl_r == ptw_pkg::LVL_PT) begin
        busy_nxt = 1'b0;
        res_kind = ptw_pkg::KIND_DONE;
        res_addr = (head_item.data & PHYS_MASK) | {{(AW-12){1'b0}}, va_r[11:0]};
      end else begin
        lvl_nxt  = lvl_dec;
        res_addr = entry_addr(head_item.data, va_r, lvl_dec) & PHYS_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      busy_r      <= 1'b0;
      lvl_r       <= ptw_pkg::LVL_PT;
      va_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_r <= cfg_wr_data;
      end
      if (pop) begin
        busy_r <= busy_nxt;
        lvl_r  <= lvl_nxt;
        va_r   <= va_nxt;
      end
      if (take_ok) begin
        out_valid_r <= pop && has_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      kind_r  <= res_kind;
      addr_r  <= res_addr;
      fault_r <= res_fault;
      size_r  <= res_size;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_address  = addr_r;
  assign out_fault    = fault_r;
  assign out_map_size = size_r;

endmodule

/* hdl/four_level_page_table_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Walks four-level page tables to translate 48-bit virtual addresses.
// ----------------------------------------------------------------------------
// Usage: a translate beat (in_cmd 0) starts a walk and produces a read request
// (out_kind 0) for the top-level entry. The caller fetches that entry and
// returns it as a reply beat (in_cmd 1). Each reply yields either the next
// read request or a finished translation (out_kind 1) with the physical
// address, the mapping size, or a fault when an entry was not present.
// Translates during a walk and replies while idle are dropped silently.
// The root table frame is written through cfg_wr_en / cfg_wr_data only while
// idle; the user is bound to this, as the block itself does not enforce it.
// A result beat passes the queue and then the output register: the accepting
// edge writes the queue and a later edge loads the output register.
// Throughput: one beat per cycle while the output is not stalled; the walk
// engine retires one queue item per cycle unless out_ready holds it back.
// When the receiver holds out_ready low, the result stays in the output
// register, the two-entry queue fills and then in_ready drops.
// Reset (synchronous, rst_n low) empties the queue, drops any result, ends
// any walk and clears the root frame to zero.
// ----------------------------------------------------------------------------
module four_level_page_table_walker #(
  parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEF,
  parameter int QUEUE_DEPTH    = ptw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ptw_pkg::ROOT_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [ptw_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [ptw_pkg::PTE_W-1:0]   in_entry_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [ptw_pkg::ADDR_W-1:0]  out_address,
  output logic                        out_fault,
  output logic [1:0]                  out_map_size
);

  // Front to queue.
  logic           q_full;
  logic           q_push;
  ptw_pkg::item_t q_item;

  // Queue to back.
  logic           head_valid;
  ptw_pkg::item_t head_item;
  logic           q_pop;

  ptw_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_virtual_address (in_virtual_address),
    .in_entry_data      (in_entry_data),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_item             (q_item)
  );

  ptw_fifo #(
    .WIDTH ($bits(ptw_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_item)
  );

  ptw_back #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_address  (out_address),
    .out_fault    (out_fault),
    .out_map_size (out_map_size)
  );

endmodule

/* hdl/ptw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [ptw_pkg::ADDR_W-1:0]  out_address,
  input logic                        out_fault,
  input logic [1:0]                  out_map_size
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_address)
      && $stable(out_kind) && $stable(out_fault) && $stable(out_map_size))
    else $error("result beat changed while stalled");

  // A fault is a finished translation at address zero with the 4K size code.
  a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_kind == ptw_pkg::KIND_DONE
      && out_address == '0 && out_map_size == ptw_pkg::SIZE_4K)
    else $error("malformed fault result");

  // Read requests point at an aligned 8-byte entry and carry no status.
  a_read_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_READ |-> !out_fault
      && out_map_size == ptw_pkg::SIZE_4K && out_address[2:0] == 3'b000)
    else $error("malformed read request");

  // Every result carries a legal size code.
  a_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_map_size == ptw_pkg::SIZE_4K
      || out_map_size == ptw_pkg::SIZE_2M || out_map_size == ptw_pkg::SIZE_1G)
    else $error("illegal page size code");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (.*);
